[rtl/core/atle_pkg.sv]
// Shared types and constants for the animation timeline engine.
// Used by atle_div, animation_timeline_engine_unit and the testbench; no dependencies.
`default_nettype none

package atle_pkg;

  // fixed field widths
  localparam int DUR_W      = 32;
  localparam int SPEED_W    = 16;
  localparam int STEP_W     = 16;
  localparam int MAXL_W     = 16;
  localparam int PROG_W     = 17;
  localparam int Q_W        = 16;
  localparam int LOOPS_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PROG_W-1:0] PROG_ONE = 17'h10000;

  // action codes
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_PAUSE  = 3'd3;
  localparam logic [2:0] ACT_RESUME = 3'd4;
  localparam logic [2:0] ACT_RESET  = 3'd5;

  // run states
  localparam logic [1:0] RUN_STOPPED  = 2'd0;
  localparam logic [1:0] RUN_PLAYING  = 2'd1;
  localparam logic [1:0] RUN_PAUSED   = 2'd2;
  localparam logic [1:0] RUN_FINISHED = 2'd3;

  // loop modes
  localparam logic [1:0] LOOP_NONE     = 2'd0;
  localparam logic [1:0] LOOP_REPEAT   = 2'd1;
  localparam logic [1:0] LOOP_PINGPONG = 2'd2;
  localparam logic [1:0] LOOP_INFINITE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOOPS   = 3'd4;

  typedef struct packed {
    logic [2:0]        action;
    logic [STEP_W-1:0] time_step;
  } atle_in_t;

  typedef struct packed {
    logic [1:0]         run_state;
    logic [PROG_W-1:0]  progress;
    logic               backward;
    logic [LOOPS_W-1:0] loops_done;
  } atle_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } atle_div_sts_t;

endpackage

`default_nettype wire

[rtl/core/atle_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, for progress.
// Depends on atle_pkg for widths and the status struct.
`default_nettype none

module atle_div import atle_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DUR_W-1:0]    rem_init,
  input  wire logic [Q_W-1:0]      num_lo,
  input  wire logic [DUR_W-1:0]    divisor,
  output atle_div_sts_t            sts,
  output logic [Q_W-1:0]           quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DUR_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   num_r, num_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic [DUR_W-1:0] div_r, div_nxt;

  logic [DUR_W:0]   trial;
  logic [DUR_W:0]   diff;
  logic             ge;

  // remainder stays below the divisor, so the trial fits one extra bit
  assign trial = {rem_r, num_r[Q_W-1]};
  assign ge    = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = rem_init;
      num_nxt  = num_lo;
      quo_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
      quo_nxt = {quo_r[Q_W-2:0], ge};
      num_nxt = {num_r[Q_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

`default_nettype wire

[rtl/core/animation_timeline_engine_unit.sv]
// Animation timeline engine top level: config registers, sequencer,
// bit-serial step*speed multiplier. Depends on atle_pkg and atle_div.
//
// One transaction is handled at a time. A tick that advances the timeline
// runs through the bit-serial multiplier for time_step * speed, the add,
// end-of-cycle and progress check steps, the restoring divider for
// elapsed/duration (quotient bits, then a done flag) and the output
// register load. Other actions, and ticks that are ignored or only use up
// the start delay, skip the multiplier, add and end-of-cycle steps. No
// division runs when the duration is zero (progress zero) or elapsed has
// reached the end (progress one). A result that is not taken holds the
// sequencer in its output step. The next transaction can be accepted in
// the cycle after the result is loaded.
`default_nettype none

module animation_timeline_engine_unit import atle_pkg::*; #(
  parameter int TIME_BITS = 32,
  parameter int LOOP_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire atle_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output atle_out_t                  out_data
);

  localparam int E_W     = TIME_BITS + 8;
  localparam int W       = ((E_W > 40) ? E_W : 40) + 1;
  localparam int MCNT_W  = $clog2(STEP_W);
  localparam int LCMP_W  = 33;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ADD  = 7'b0000100,
    ST_WRAP = 7'b0001000,
    ST_PROG = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [DUR_W-1:0]         duration_r, duration_nxt;
  logic [SPEED_W-1:0]       speed_r, speed_nxt;
  logic [1:0]               loop_mode_r, loop_mode_nxt;
  logic signed [MAXL_W-1:0] max_loops_r, max_loops_nxt;
  logic [1:0]               play_r, play_nxt;
  logic [E_W-1:0]           elapsed_r, elapsed_nxt;
  logic [DUR_W-1:0]         delay_r, delay_nxt;
  logic [LOOP_BITS-1:0]     loop_cnt_r, loop_cnt_nxt;
  logic                     rev_r, rev_nxt;
  logic [STEP_W-1:0]        mplier_r, mplier_nxt;
  logic [2*STEP_W-1:0]      product_r, product_nxt;
  logic [MCNT_W-1:0]        mcnt_r, mcnt_nxt;
  logic [PROG_W-1:0]        prog_r, prog_nxt;
  logic                     out_valid_r, out_valid_nxt;
  atle_out_t                out_data_r, out_data_nxt;

  logic [W-1:0]             elapsed_w, end_w, sum_w, elapsed_max_w;
  logic [DUR_W-1:0]         rem_src;
  logic                     at_end;
  logic [LOOP_BITS-1:0]     cnt_inc;
  logic                     may_loop;
  logic [LCMP_W-1:0]        loop_ext;
  logic                     div_start;
  atle_div_sts_t            div_sts;
  logic [Q_W-1:0]           div_quo;

  assign elapsed_w     = W'(elapsed_r);
  assign end_w         = W'({duration_r, 8'b0});
  assign elapsed_max_w = W'({E_W{1'b1}});
  assign sum_w         = elapsed_w + W'(product_r);
  assign at_end        = (duration_r != '0) && (elapsed_w >= end_w);
  // integer part of elapsed; below the duration whenever a division runs
  assign rem_src       = elapsed_w[DUR_W+7:8];
  assign cnt_inc       = (&loop_cnt_r) ? loop_cnt_r : loop_cnt_r + 1'b1;
  assign may_loop      = max_loops_r[MAXL_W-1] ||
                         (LCMP_W'(cnt_inc) < LCMP_W'(max_loops_r[MAXL_W-2:0]));
  assign loop_ext      = LCMP_W'(loop_cnt_r);

  atle_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (rem_src),
    .num_lo   ({elapsed_r[7:0], 8'b0}),
    .divisor  (duration_r),
    .sts      (div_sts),
    .quo      (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    duration_nxt  = duration_r;
    speed_nxt     = speed_r;
    loop_mode_nxt = loop_mode_r;
    max_loops_nxt = max_loops_r;
    play_nxt      = play_r;
    elapsed_nxt   = elapsed_r;
    delay_nxt     = delay_r;
    loop_cnt_nxt  = loop_cnt_r;
    rev_nxt       = rev_r;
    mplier_nxt    = mplier_r;
    product_nxt   = product_r;
    mcnt_nxt      = mcnt_r;
    prog_nxt      = prog_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    in_ready      = (state_r == ST_IDLE);

    if (cfg_we) begin
      case (cfg_idx)
        CFG_DURATION:    duration_nxt  = cfg_wdata[DUR_W-1:0];
        CFG_SPEED:       speed_nxt     = cfg_wdata[SPEED_W-1:0];
        CFG_START_DELAY: delay_nxt     = cfg_wdata[DUR_W-1:0];
        CFG_LOOP_MODE:   loop_mode_nxt = cfg_wdata[1:0];
        CFG_MAX_LOOPS:   max_loops_nxt = cfg_wdata[MAXL_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mplier_nxt  = in_data.time_step;
          product_nxt = '0;
          mcnt_nxt    = '0;
          state_nxt   = ST_PROG;
          case (in_data.action)
            ACT_TICK: begin
              if (play_r == RUN_PLAYING) begin
                if (delay_r != '0) begin
                  delay_nxt = (delay_r > DUR_W'(in_data.time_step)) ?
                              delay_r - DUR_W'(in_data.time_step) : '0;
                end else begin
                  state_nxt = ST_MUL;
                end
              end
            end
            ACT_START: begin
              play_nxt     = RUN_PLAYING;
              elapsed_nxt  = '0;
              loop_cnt_nxt = '0;
            end
            ACT_STOP: begin
              play_nxt    = RUN_STOPPED;
              elapsed_nxt = '0;
            end
            ACT_PAUSE: begin
              if (play_r == RUN_PLAYING) play_nxt = RUN_PAUSED;
            end
            ACT_RESUME: begin
              if (play_r == RUN_PAUSED) play_nxt = RUN_PLAYING;
            end
            ACT_RESET: begin
              elapsed_nxt  = '0;
              loop_cnt_nxt = '0;
              rev_nxt      = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        // MSB-first shift-and-add
        product_nxt = {product_r[2*STEP_W-2:0], 1'b0} +
                      (mplier_r[STEP_W-1] ? (2*STEP_W)'(speed_r) : '0);
        mplier_nxt  = {mplier_r[STEP_W-2:0], 1'b0};
        mcnt_nxt    = mcnt_r + 1'b1;
        if (mcnt_r == MCNT_W'(STEP_W - 1)) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        elapsed_nxt = (sum_w > elapsed_max_w) ? '1 : sum_w[E_W-1:0];
        state_nxt   = ST_WRAP;
      end
      ST_WRAP: begin
        if (at_end) begin
          loop_cnt_nxt = cnt_inc;
          case (loop_mode_r)
            LOOP_NONE: begin
              play_nxt    = RUN_FINISHED;
              elapsed_nxt = (end_w > elapsed_max_w) ? '1 : end_w[E_W-1:0];
            end
            LOOP_REPEAT: begin
              if (may_loop) elapsed_nxt = '0;
              else          play_nxt    = RUN_FINISHED;
            end
            LOOP_PINGPONG: begin
              if (may_loop) begin
                rev_nxt     = ~rev_r;
                elapsed_nxt = '0;
              end else begin
                play_nxt = RUN_FINISHED;
              end
            end
            default: elapsed_nxt = '0;
          endcase
        end
        state_nxt = ST_PROG;
      end
      ST_PROG: begin
        if (duration_r == '0) begin
          prog_nxt  = '0;
          state_nxt = ST_OUT;
        end else if (at_end) begin
          prog_nxt  = PROG_ONE;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          prog_nxt  = PROG_W'(div_quo);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.run_state  = play_r;
          out_data_nxt.progress   = (rev_r && duration_r != '0) ?
                                    PROG_ONE - prog_r : prog_r;
          out_data_nxt.backward   = rev_r;
          out_data_nxt.loops_done = (loop_ext > LCMP_W'(16'hFFFF)) ?
                                    '1 : loop_ext[LOOPS_W-1:0];
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      duration_r  <= '0;
      speed_r     <= SPEED_W'(256);
      loop_mode_r <= LOOP_NONE;
      max_loops_r <= MAXL_W'(1);
      play_r      <= RUN_STOPPED;
      elapsed_r   <= '0;
      delay_r     <= '0;
      loop_cnt_r  <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      duration_r  <= duration_nxt;
      speed_r     <= speed_nxt;
      loop_mode_r <= loop_mode_nxt;
      max_loops_r <= max_loops_nxt;
      play_r      <= play_nxt;
      elapsed_r   <= elapsed_nxt;
      delay_r     <= delay_nxt;
      loop_cnt_r  <= loop_cnt_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mplier_r   <= mplier_nxt;
    product_r  <= product_nxt;
    mcnt_r     <= mcnt_nxt;
    prog_r     <= prog_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while sequencer busy");

  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.progress <= PROG_ONE)
    else $error("progress above one");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_DIV |-> !div_sts.busy)
    else $error("divider running outside divide state");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("divider result not awaited");

endmodule

`default_nettype wire

[tb/sv/atle_timeline_checker.sv]
// Scoreboard for the animation timeline engine: tracks register writes, predicts one
// status result per accepted action and compares it with what the block returns.
// Depends on atle_pkg.
`timescale 1ns / 100ps

module atle_timeline_checker import atle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  atle_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  atle_out_t             out_data,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  // shadow registers
  logic [31:0]        reg_duration;
  logic [15:0]        reg_speed;
  logic [1:0]         reg_loop_mode;
  logic signed [15:0] reg_max_loops;

  // timeline state, elapsed in 32.8 fixed point
  logic [1:0]  tl_state;
  logic [39:0] tl_elapsed;
  logic [31:0] tl_delay;
  logic [15:0] tl_loops;
  logic        tl_reverse;

  atle_out_t status_q[$];
  int n_fail;
  int n_checked;

  task automatic timeline_step(input atle_in_t txn, output atle_out_t res);
    logic [31:0]       add;
    logic [40:0]       sum;
    logic [39:0]       end_t;
    logic [63:0]       ratio;
    logic [PROG_W-1:0] prog;
    end_t = {reg_duration, 8'd0};
    case (txn.action)
      ACT_TICK: begin
        if (tl_state == RUN_PLAYING) begin
          if (tl_delay != '0) begin
            // the delay eats the whole tick
            tl_delay = (tl_delay > 32'(txn.time_step)) ?
                       tl_delay - 32'(txn.time_step) : '0;
          end else begin
            add = 32'(txn.time_step) * 32'(reg_speed);
            sum = {1'b0, tl_elapsed} + {9'd0, add};
            tl_elapsed = sum[40] ? '1 : sum[39:0];
            if (reg_duration != '0 && tl_elapsed >= end_t) begin
              if (tl_loops != '1) tl_loops++;
              case (reg_loop_mode)
                LOOP_NONE: begin
                  tl_state = RUN_FINISHED;
                  tl_elapsed = end_t;
                end
                LOOP_INFINITE: tl_elapsed = '0;
                default: begin
                  if (reg_max_loops < 0 || int'(tl_loops) < int'(reg_max_loops)) begin
                    if (reg_loop_mode == LOOP_PINGPONG) tl_reverse = ~tl_reverse;
                    tl_elapsed = '0;
                  end else begin
                    tl_state = RUN_FINISHED;
                  end
                end
              endcase
            end
          end
        end
      end
      ACT_START: begin
        tl_state = RUN_PLAYING;
        tl_elapsed = '0;
        tl_loops = '0;
      end
      ACT_STOP: begin
        tl_state = RUN_STOPPED;
        tl_elapsed = '0;
      end
      ACT_PAUSE: begin
        if (tl_state == RUN_PLAYING) tl_state = RUN_PAUSED;
      end
      ACT_RESUME: begin
        if (tl_state == RUN_PAUSED) tl_state = RUN_PLAYING;
      end
      ACT_RESET: begin
        tl_elapsed = '0;
        tl_loops = '0;
        tl_reverse = 1'b0;
      end
      default: ;
    endcase

    if (reg_duration == '0) begin
      prog = '0;
    end else begin
      if (tl_elapsed >= end_t) begin
        prog = PROG_ONE;
      end else begin
        ratio = {16'd0, tl_elapsed, 8'd0} / {32'd0, reg_duration};
        prog = ratio[PROG_W-1:0];
      end
      if (tl_reverse) prog = PROG_ONE - prog;
    end
    res.run_state  = tl_state;
    res.progress   = prog;
    res.backward   = tl_reverse;
    res.loops_done = tl_loops;
  endtask

  task automatic report_field(input string fname, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (got_v !== want_v) begin
      n_fail++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : monitor
    atle_out_t want;
    if (!rst_n) begin
      reg_duration    = '0;
      reg_speed       = 16'd256;
      reg_loop_mode   = LOOP_NONE;
      reg_max_loops   = 16'sd1;
      tl_state        = RUN_STOPPED;
      tl_elapsed      = '0;
      tl_delay        = '0;
      tl_loops        = '0;
      tl_reverse      = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DURATION:    reg_duration = cfg_wdata;
          CFG_SPEED:       reg_speed = cfg_wdata[15:0];
          CFG_START_DELAY: tl_delay = cfg_wdata;
          CFG_LOOP_MODE:   reg_loop_mode = cfg_wdata[1:0];
          CFG_MAX_LOOPS:   reg_max_loops = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        timeline_step(in_data, want);
        status_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          n_fail++;
          $display("%0t ns: unexpected result, expected none, actual state %0d progress %0d",
                   $time, out_data.run_state, out_data.progress);
        end else begin
          want = status_q.pop_front();
          report_field("run_state", 32'(want.run_state), 32'(out_data.run_state));
          report_field("progress", 32'(want.progress), 32'(out_data.progress));
          report_field("backward", 32'(want.backward), 32'(out_data.backward));
          report_field("loops_done", 32'(want.loops_done), 32'(out_data.loops_done));
          n_checked++;
        end
      end
    end
    fail_count <= n_fail;
    pending    <= status_q.size();
    checked    <= n_checked;
  end

endmodule

[tb/sv/tb_animation_timeline_engine_unit.sv]
// Top of the animation timeline engine testbench: clock, reset, register setup and
// action stimulus. Depends on atle_pkg, the engine RTL and atle_timeline_checker.
`timescale 1ns / 100ps

module tb_animation_timeline_engine_unit;
  import atle_pkg::*;

  localparam logic [2:0]           ACT_RSVD_6    = 3'd6;
  localparam logic [2:0]           ACT_RSVD_7    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  atle_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  atle_out_t             out_data;

  int fail_count;
  int pending;
  int checked;
  int tx_idle_pct;
  int rx_idle_pct;
  int sent_count;
  int regs_written;

  animation_timeline_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  atle_timeline_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_action(input logic [2:0] act, input logic [15:0] step);
    // each cycle before the transaction the sender may sit idle
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= atle_in_t'{action: act, time_step: step};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    regs_written++;
  endtask

  // mask bits select duration, speed, delay, mode, max loops, unused index
  task automatic apply_settings(input logic [5:0] mask, input logic [31:0] dur,
                                input logic [15:0] spd, input logic [31:0] dly,
                                input logic [1:0] mode, input logic [15:0] maxl);
    if (mask[0]) cfg_write(CFG_DURATION, dur);
    if (mask[1]) cfg_write(CFG_SPEED, {16'd0, spd});
    if (mask[2]) cfg_write(CFG_START_DELAY, dly);
    if (mask[3]) cfg_write(CFG_LOOP_MODE, {30'd0, mode});
    if (mask[4]) cfg_write(CFG_MAX_LOOPS, {16'd0, maxl});
    if (mask[5]) cfg_write(CFG_IDX_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  // drain all outstanding results, then give the sequencer time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  initial begin
    int          ph;
    int          k;
    int          n_ops;
    int          phase_base;
    logic [31:0] dur;
    logic [31:0] dly;
    logic [15:0] spd;
    logic [15:0] maxl;
    logic [15:0] step;
    logic [1:0]  mode;
    logic [2:0]  act;

    tx_idle_pct = 19;
    rx_idle_pct = 60;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored actions from stopped, reserved codes
    send_action(ACT_TICK, 16'hFFFF);
    send_action(ACT_PAUSE, 16'h0000);
    send_action(ACT_RESUME, 16'hFFFF);
    send_action(ACT_RSVD_6, 16'hFFFF);
    send_action(ACT_RSVD_7, 16'h0000);
    settle();
    // ping-pong, two loops, with a start delay
    apply_settings(6'b111111, 32'd100, 16'd256, 32'd50, LOOP_PINGPONG, 16'd2);
    send_action(ACT_START, 16'h1234);
    send_action(ACT_TICK, 16'd30);
    send_action(ACT_TICK, 16'hFFFF);
    send_action(ACT_TICK, 16'd40);
    send_action(ACT_PAUSE, 16'd0);
    send_action(ACT_TICK, 16'd10);
    send_action(ACT_RESUME, 16'd0);
    send_action(ACT_TICK, 16'd60);
    send_action(ACT_TICK, 16'd50);
    send_action(ACT_TICK, 16'd50);
    send_action(ACT_RESUME, 16'd0);
    send_action(ACT_RESET, 16'hFFFF);
    settle();
    // single shot ends with elapsed pinned to the duration
    apply_settings(6'b011011, 32'd3, 16'hFFFF, 32'd0, LOOP_NONE, 16'h8000);
    send_action(ACT_START, 16'd0);
    send_action(ACT_TICK, 16'd0);
    send_action(ACT_TICK, 16'hFFFF);
    send_action(ACT_STOP, 16'd0);
    settle();
    // zero speed never advances
    apply_settings(6'b011011, 32'hFFFFFFFF, 16'd0, 32'd0, LOOP_INFINITE, 16'd0);
    send_action(ACT_START, 16'd0);
    send_action(ACT_TICK, 16'hFFFF);
    settle();
    // repeat with limit zero finishes on the first loop
    apply_settings(6'b011011, 32'd1, 16'd256, 32'd0, LOOP_REPEAT, 16'd0);
    send_action(ACT_START, 16'd0);
    send_action(ACT_TICK, 16'd1);

    // elapsed saturation with zero duration, then a finite duration exposes it
    settle();
    apply_settings(6'b011111, 32'd0, 16'hFFFF, 32'd0, LOOP_PINGPONG, 16'hFFFF);
    send_action(ACT_START, 16'd0);
    repeat (260) send_action(ACT_TICK, 16'hFFFF);
    settle();
    apply_settings(6'b000001, 32'hFFFFFFFF, 16'd0, 32'd0, LOOP_NONE, 16'd0);
    send_action(ACT_PAUSE, 16'd0);
    send_action(ACT_RESUME, 16'd0);
    send_action(ACT_TICK, 16'd1);
    send_action(ACT_TICK, 16'hFFFF);
    send_action(ACT_RESET, 16'd0);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 19; rx_idle_pct = 60; end
        1: begin tx_idle_pct = 60; rx_idle_pct = 19; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      phase_base = sent_count;
      while (sent_count - phase_base < 365) begin
        settle();
        case ($urandom_range(9))
          0: dur = 32'd0;
          1: dur = 32'd1;
          2, 3, 4: dur = $urandom_range(2, 300);
          5, 6: dur = $urandom_range(301, 100000);
          7: dur = $urandom;
          8: dur = 32'hFFFFFFFF;
          default: dur = $urandom_range(1, 20);
        endcase
        case ($urandom_range(7))
          0: spd = 16'd0;
          1, 2: spd = 16'd256;
          3, 4: spd = 16'($urandom_range(1, 1024));
          5: spd = 16'hFFFF;
          default: spd = 16'($urandom);
        endcase
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: dly = 32'd0;
          10, 11, 12, 13, 14, 15, 16: dly = $urandom_range(1, 3000);
          17, 18: dly = $urandom;
          default: dly = 32'hFFFFFFFF;
        endcase
        case ($urandom_range(9))
          0, 1: maxl = 16'hFFFF;
          2: maxl = 16'd0;
          3, 4, 5: maxl = 16'($urandom_range(1, 5));
          6: maxl = 16'h7FFF;
          7: maxl = 16'h8000;
          default: maxl = 16'($urandom);
        endcase
        mode = 2'($urandom_range(3));
        apply_settings(6'($urandom_range(1, 63)), dur, spd, dly, mode, maxl);

        if ($urandom_range(99) < 85) send_action(ACT_START, 16'($urandom));
        n_ops = $urandom_range(4, 36);
        for (k = 0; k < n_ops; k++) begin
          case ($urandom_range(7))
            0: step = 16'd0;
            1: step = 16'hFFFF;
            2, 3: step = 16'($urandom_range(0, 15));
            4, 5, 6: step = 16'($urandom_range(0, 1500));
            default: step = 16'($urandom);
          endcase
          if ($urandom_range(99) < 72) begin
            act = ACT_TICK;
          end else begin
            case ($urandom_range(6))
              0: act = ACT_START;
              1: act = ACT_STOP;
              2: act = ACT_PAUSE;
              3: act = ACT_RESUME;
              4: act = ACT_RESET;
              5: act = ACT_RSVD_6;
              default: act = ACT_RSVD_7;
            endcase
          end
          send_action(act, step);
        end
      end
    end

    settle();
    $display("Covered %0d actions (directed cases, elapsed saturation, random loop scenarios)",
             sent_count);
    $display("with %0d register writes under three flow-control mixes; %0d results compared.",
             regs_written, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
